FILE: hw/rtl/b85_pkg.sv
// Shared types, constants and the digit decode table for the base-85 text decoder.
// No dependencies; imported by every module of the block.
package b85_pkg;

  localparam int unsigned RADIX     = 85;
  localparam int unsigned LOW_CHAR  = 32;
  localparam int unsigned HIGH_CHAR = 127;
  localparam logic [7:0]  NO_DIGIT  = 8'hFF;

  localparam int unsigned GROUP_DIGITS = 5;
  localparam int unsigned TABLE_SIZE   = 96;
  localparam int unsigned WEIGHT_W     = 26;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic       KIND_CHAR  = 1'b0;
  localparam logic       KIND_FLUSH = 1'b1;

  localparam logic [7:0] DIGIT_TABLE [TABLE_SIZE] = '{
    8'hFF, 8'h44, 8'hFF, 8'h54, 8'h53, 8'h52, 8'hFF, 8'h49, 8'h4B, 8'h4C, 8'h46, 8'h41,
    8'hFF, 8'h3F, 8'h3E, 8'h45, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h40, 8'hFF, 8'hFF, 8'h42, 8'hFF, 8'h47, 8'h51, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h4D,
    8'hFF, 8'h4E, 8'h43, 8'hFF, 8'h48, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C,
    8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h4F, 8'h4A, 8'h50, 8'hFF, 8'hFF
  };

  localparam logic [WEIGHT_W-1:0] PLACE_WEIGHT [GROUP_DIGITS] = '{
    WEIGHT_W'(1),
    WEIGHT_W'(RADIX),
    WEIGHT_W'(RADIX * RADIX),
    WEIGHT_W'(RADIX * RADIX * RADIX),
    WEIGHT_W'(RADIX * RADIX * RADIX * RADIX)
  };

  // One queued output job: a word and how many of its low bytes to send.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        from_flush;
  } job_t;

  function automatic logic [7:0] digit_of(input logic [7:0] ch);
    logic [7:0] offs;
    offs = ch - 8'(LOW_CHAR);
    if (ch < 8'(LOW_CHAR) || ch > 8'(HIGH_CHAR)) begin
      return NO_DIGIT;
    end
    return DIGIT_TABLE[offs[6:0]];
  endfunction

endpackage

FILE: hw/rtl/b85_front.sv
// Front end: accepts characters, decodes digits, accumulates groups and queues output jobs.
// Depends on b85_pkg.
module b85_front
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] kind
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [2:0]  digit_phase;
  logic [31:0] word_accum;
  logic [2:0]  digit_phase_next;
  logic [31:0] word_accum_next;

  logic        accept;
  logic [7:0]  digit;
  logic        digit_ok;
  logic [31:0] product;
  logic [31:0] accum_sum;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign digit    = digit_of(s_tdata);
  assign digit_ok = (digit != NO_DIGIT) && (digit < 8'(RADIX));
  assign product  = 32'(digit[6:0]) * 32'(PLACE_WEIGHT[digit_phase]);
  assign accum_sum = (digit_phase == 3'd0) ? 32'(digit[6:0]) : word_accum + product;

  always_comb begin
    digit_phase_next    = digit_phase;
    word_accum_next     = word_accum;
    push                = 1'b0;
    push_job.word       = word_accum;
    push_job.count      = 3'd0;
    push_job.from_flush = 1'b0;
    if (accept) begin
      if (s_tuser == KIND_FLUSH) begin
        push_job.from_flush = 1'b1;
        if (digit_phase >= 3'd2) begin
          push_job.count = digit_phase - 3'd1;
          push           = 1'b1;
        end
        digit_phase_next = 3'd0;
        word_accum_next  = 32'd0;
      end else if (digit_ok) begin
        word_accum_next = accum_sum;
        push_job.word   = accum_sum;
        if (digit_phase == 3'(GROUP_DIGITS - 1)) begin
          push_job.count   = 3'd4;
          push             = 1'b1;
          digit_phase_next = 3'd0;
        end else begin
          digit_phase_next = digit_phase + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_phase <= 3'd0;
      word_accum  <= 32'd0;
    end else begin
      digit_phase <= digit_phase_next;
      word_accum  <= word_accum_next;
    end
  end

endmodule

FILE: hw/rtl/b85_queue.sv
// Short job queue between the decoder front end and the byte sender.
// Depends on b85_pkg.
module b85_queue
  import b85_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  assign full    = (fill == QFILL_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + QFILL_W'(push && !full) - QFILL_W'(pop && !empty);
    end
  end

endmodule

FILE: hw/rtl/b85_back.sv
// Back end: takes jobs from the queue and sends their bytes low first through an output register.
// Depends on b85_pkg.
module b85_back
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic       m_tlast,   // last_in_run
  output logic       m_tuser    // [0] from_flush
);

  logic        busy;
  logic [31:0] word;
  logic [2:0]  remaining;
  logic        flush;

  logic        emit;
  logic        emit_last;

  assign emit      = busy && (!m_tvalid || m_tready);
  assign emit_last = emit && (remaining == 3'd1);
  assign pop       = !q_empty && (!busy || emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata   <= word[7:0];
      m_tlast   <= (remaining == 3'd1);
      m_tuser   <= flush;
      word      <= word >> 8;
      remaining <= remaining - 3'd1;
    end
    if (pop) begin
      word      <= q_job.word;
      remaining <= q_job.count;
      flush     <= q_job.from_flush;
    end
  end

endmodule

FILE: hw/rtl/base85_text_decoder.sv
// Top level of the streaming base-85 text decoder: front end, job queue and byte sender.
// Depends on b85_pkg, b85_front, b85_queue and b85_back.
//
// Characters enter one per cycle on the s_ side (tuser = 1 marks end of text) while the
// four-entry job queue has room. A fifth digit queues a four-byte word; an end-of-text item
// with two to four pending digits queues one to three bytes. The back end sends one byte per
// cycle on the m_ side while m_tready allows, through the queue slot, the word register and
// the output register. The input side sets sustained throughput: five digits give four
// bytes, and the front end stalls only when the queue fills behind a stalled output.
module base85_text_decoder
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic       m_tlast,   // last_in_run
  output logic       m_tuser    // [0] from_flush
);

  logic push;
  job_t push_job;
  logic pop;
  job_t pop_job;
  logic q_full;
  logic q_empty;

  b85_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  b85_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b85_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for base85_text_decoder: streams text and end-of-text items and
// checks every decoded byte against an in-bench decoder. Needs b85_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import b85_pkg::KIND_CHAR;
  import b85_pkg::KIND_FLUSH;

  localparam int unsigned FIRST_TEXT_CHAR = 32;
  localparam int unsigned LAST_TEXT_CHAR  = 127;
  localparam logic [7:0]  NOT_A_DIGIT     = 8'hFF;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_PRINTS      = 50;

  localparam logic [7:0] CHAR_DIGIT [96] = '{
    8'hFF, 8'h44, 8'hFF, 8'h54, 8'h53, 8'h52, 8'hFF, 8'h49, 8'h4B, 8'h4C, 8'h46, 8'h41,
    8'hFF, 8'h3F, 8'h3E, 8'h45, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h40, 8'hFF, 8'hFF, 8'h42, 8'hFF, 8'h47, 8'h51, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h4D,
    8'hFF, 8'h4E, 8'h43, 8'hFF, 8'h48, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C,
    8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h4F, 8'h4A, 8'h50, 8'hFF, 8'hFF
  };

  localparam logic [31:0] DIGIT_WEIGHT [5] = '{
    32'd1, 32'd85, 32'd7225, 32'd614125, 32'd52200625
  };

  typedef struct {
    logic [7:0] data_byte;
    logic       is_last;
    logic       is_flush;
  } decoded_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  decoded_byte_t expected_bytes [$];
  logic [2:0]    group_phase = 3'd0;
  logic [31:0]   group_word = 32'd0;
  logic [7:0]    char_of_digit [85];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_run = 0;
  bit          send_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  bit          rx_ready_phase = 1'b1;
  bit          hold_request = 1'b0;

  base85_text_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("mismatch on %s: got %02h, want %02h at %0t ns", field, got, want, $time);
    end
  endtask

  task automatic add_expected(input decoded_byte_t b);
    expected_bytes.insert(expected_bytes.size(), b);
  endtask

  task automatic decode_item(input logic kind, input logic [7:0] ch);
    logic [7:0] digit;
    int         n_bytes;
    if (kind == KIND_FLUSH) begin
      n_bytes = (group_phase >= 3'd2) ? int'(group_phase) - 1 : 0;
      for (int k = 0; k < n_bytes; k++) begin
        add_expected('{group_word[8*k +: 8], k == n_bytes - 1, 1'b1});
      end
      group_phase = 3'd0;
      group_word  = 32'd0;
      return;
    end
    if (ch < FIRST_TEXT_CHAR || ch > LAST_TEXT_CHAR) return;
    digit = CHAR_DIGIT[int'(ch) - FIRST_TEXT_CHAR];
    if (digit == NOT_A_DIGIT) return;
    if (group_phase == 3'd0) group_word = 32'(digit);
    else group_word = group_word + 32'(digit) * DIGIT_WEIGHT[group_phase];
    group_phase++;
    if (group_phase == 3'd5) begin
      for (int k = 0; k < 4; k++) begin
        add_expected('{group_word[8*k +: 8], k == 3, 1'b0});
      end
      group_phase = 3'd0;
    end
  endtask

  task automatic send_item(input logic kind, input logic [7:0] ch);
    int unsigned gap;
    if (send_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_item(kind, ch);
  endtask

  task automatic send_digit(input int unsigned digit);
    send_item(KIND_CHAR, char_of_digit[digit]);
  endtask

  task automatic test_directed;
    send_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_item(KIND_FLUSH, 8'h00);
    send_digit(84);
    send_item(KIND_FLUSH, 8'h00);
    send_digit(0);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'hFF);
    send_digit(84);
    send_item(KIND_FLUSH, 8'h5A);
    send_digit(84);
    send_item(KIND_CHAR, 8'd31);
    send_digit(0);
    send_digit(84);
    send_item(KIND_FLUSH, 8'h00);
    repeat (4) send_digit(84);
    send_item(KIND_FLUSH, 8'hFF);
    send_digit(84);
    send_item(KIND_CHAR, 8'd128);
    send_digit(84);
    send_item(KIND_CHAR, 8'd127);
    send_item(KIND_CHAR, 8'd32);
    repeat (3) send_digit(84);
  endtask

  task automatic test_random_text(input int unsigned n_items, input bit with_idling);
    int unsigned counted;
    int unsigned len;
    int unsigned pick;
    int unsigned digit;
    send_gaps = with_idling;
    rx_stalls = with_idling;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 5;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
            counted++;
          end
          case ($urandom_range(0, 7))
            0: digit = 0;
            1: digit = 84;
            default: digit = $urandom_range(0, 84);
          endcase
          send_digit(digit);
          counted++;
        end
        if (len < 5 || $urandom_range(0, 5) == 0) begin
          send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
          counted++;
        end
      end else if (pick < 9) begin
        send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
        counted++;
      end else begin
        send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
        counted++;
      end
    end
  endtask

  task automatic test_backpressure;
    send_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_digit($urandom_range(0, 84));
    send_item(KIND_FLUSH, 8'h00);
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_ready_phase = !rx_ready_phase;
        rx_run = rx_ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 6);
      end
      rx_run--;
      m_tready <= rx_ready_phase;
    end
  end

  always @(posedge clk) begin : check_bytes
    decoded_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected item", m_tdata, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.data_byte) report_mismatch("data_byte", m_tdata, want.data_byte);
        if (m_tlast !== want.is_last) begin
          report_mismatch("last_in_run", 8'(m_tlast), 8'(want.is_last));
        end
        if (m_tuser !== want.is_flush) begin
          report_mismatch("from_flush", 8'(m_tuser), 8'(want.is_flush));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int c = FIRST_TEXT_CHAR; c <= LAST_TEXT_CHAR; c++) begin
      if (CHAR_DIGIT[c - FIRST_TEXT_CHAR] != NOT_A_DIGIT) begin
        char_of_digit[CHAR_DIGIT[c - FIRST_TEXT_CHAR]] = 8'(c);
      end
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text(200, 1'b1);
    test_random_text(80, 1'b0);
    test_backpressure();
    test_random_text(70, 1'b1);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
